FILE: rtl/core/spfi_pkg.sv
// Shared types, register codes and constants of the surface pressure force integrator.
// Used by every module under rtl/core except spfi_div; depends on nothing else.
package spfi_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int ACC_WIDTH_DEF = 64;
  localparam int ANGLE_FRAC    = 30;
  localparam int SCALE_FRAC    = 32;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_COS_INCIDENCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN_INCIDENCE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEFF_SCALE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENT_REF_X  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MOMENT_REF_Y  = 3'd4;

  localparam logic signed [31:0] COS_RESET   = 32'sh4000_0000;
  localparam logic signed [31:0] SIN_RESET   = 32'sh0000_0000;
  localparam logic [47:0]        SCALE_RESET = 48'h0001_0000_0000;
  localparam logic signed [31:0] REF_X_RESET = 32'sh0040_0000;
  localparam logic signed [31:0] REF_Y_RESET = 32'sh0000_0000;

  // Pressure is 0.4 times the internal energy. For a magnitude a below 2^33, twice a over
  // five truncated equals (a * PRESSURE_RECIP) >> 33 exactly.
  localparam logic [31:0] PRESSURE_RECIP = 32'hCCCC_CCCD;
  // Magnitudes of a negative energy difference from here on give a pressure below -2^31.
  localparam logic [63:0] PRESSURE_SAT_MAG = 64'd5368709123;

  // Depth of the point queue between the front and the back.
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [31:0] cos_incidence;
    logic signed [31:0] sin_incidence;
    logic [47:0]        coeff_scale;
    logic signed [31:0] moment_ref_x;
    logic signed [31:0] moment_ref_y;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] pressure;
    logic               last;
    logic               dfault;
    logic               psat;
  } point_t;

  typedef enum logic [1:0] {SH_FRAC, SH_ANGLE, SH_SCALE} shift_t;
  typedef enum logic [1:0] {LIM_FULL, LIM_ACC, LIM_ROT, LIM_OUT} limit_t;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
    shift_t             shf;
    limit_t             lim;
  } mul_cmd_t;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mul_state_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_KIN, F_DIV1, F_SUB, F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {B_IDLE, B_ISSUE, B_WAIT, B_OUT} back_state_t;

  typedef enum logic [3:0] {
    OP_LEV_X, OP_LEV_Y, OP_FX, OP_FY, OP_MOM,
    OP_LIFT_C, OP_LIFT_S, OP_DRAG_S, OP_DRAG_C,
    OP_CL, OP_CD, OP_CM
  } op_t;

endpackage

FILE: rtl/core/surface_pressure_force_integrator.sv
// Usage: wall points of one surface are written in order through push/full; a transfer
// happens at a clock edge with push high and full low. The point flagged is_last closes the
// surface and produces one result: lift, drag and moment coefficients plus two flags.
// Results leave through empty/pop; the oldest result is on the ports while empty is low and
// is transferred at an edge with pop high. A single result register holds it, so the front
// keeps taking points and the back keeps integrating until a second result is ready.
// The point rate is set by the bit-serial divider that forms kinetic energy over density;
// the scale by two fifths is done in a single state after it. A zero-density point skips
// the divider. The back issues five shared multiplier operations per segment and seven
// more on the last point.
// A two-entry point queue between front and back lets either side stall on its own; while
// the receiver stalls, the queue fills and full stays high.
// Configuration is written through cfg_write/cfg_index/cfg_data while the block is idle;
// indexes outside the register list are ignored. Synchronous reset returns the registers to
// their defaults and clears the surface state; no clearing pass is needed.
// Depends on spfi_pkg, spfi_front, spfi_fifo, spfi_back.
module surface_pressure_force_integrator import spfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic signed [31:0]     coord_x,
  input  logic signed [31:0]     coord_y,
  input  logic [30:0]            density,
  input  logic signed [31:0]     momentum_x,
  input  logic signed [31:0]     momentum_y,
  input  logic [30:0]            energy_total,
  input  logic                   is_last,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [31:0]     lift_coeff,
  output logic signed [31:0]     drag_coeff,
  output logic signed [31:0]     moment_coeff,
  output logic                   density_fault,
  output logic                   saturated
);

  cfg_t   cfg;
  point_t f_data, b_data;
  logic   f_push, q_full, q_empty, b_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_incidence <= COS_RESET;
      cfg.sin_incidence <= SIN_RESET;
      cfg.coeff_scale   <= SCALE_RESET;
      cfg.moment_ref_x  <= REF_X_RESET;
      cfg.moment_ref_y  <= REF_Y_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_COS_INCIDENCE: cfg.cos_incidence <= $signed(cfg_data[31:0]);
        REG_SIN_INCIDENCE: cfg.sin_incidence <= $signed(cfg_data[31:0]);
        REG_COEFF_SCALE:   cfg.coeff_scale   <= cfg_data;
        REG_MOMENT_REF_X:  cfg.moment_ref_x  <= $signed(cfg_data[31:0]);
        REG_MOMENT_REF_Y:  cfg.moment_ref_y  <= $signed(cfg_data[31:0]);
        default: ;
      endcase
    end
  end

  spfi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .density      (density),
    .momentum_x   (momentum_x),
    .momentum_y   (momentum_y),
    .energy_total (energy_total),
    .is_last      (is_last),
    .q_full       (q_full),
    .q_push       (f_push),
    .q_data       (f_data)
  );

  spfi_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (f_push),
    .wdata (f_data),
    .full  (q_full),
    .rd    (b_pop),
    .rdata (b_data),
    .empty (q_empty)
  );

  spfi_back #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_pop         (b_pop),
    .q_data        (b_data),
    .pop           (pop),
    .empty         (empty),
    .lift_coeff    (lift_coeff),
    .drag_coeff    (drag_coeff),
    .moment_coeff  (moment_coeff),
    .density_fault (density_fault),
    .saturated     (saturated)
  );

endmodule

FILE: rtl/core/spfi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// Depends on nothing but the clock and reset.
module spfi_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [32:0] trial_sub;
  logic        ge;

  assign trial     = {rem, quo[63]};
  assign trial_sub = trial - {1'b0, dvs};
  assign ge        = trial >= {1'b0, dvs};
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[31:0] : trial[31:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

FILE: rtl/core/spfi_front.sv
// Front part: takes wall points and forms each point's static pressure.
// Depends on spfi_pkg and spfi_div.
module spfi_front import spfi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic [30:0]        density,
  input  logic signed [31:0] momentum_x,
  input  logic signed [31:0] momentum_y,
  input  logic [30:0]        energy_total,
  input  logic               is_last,
  input  logic               q_full,
  output logic               q_push,
  output point_t             q_data
);

  front_state_t state, state_next;

  logic signed [31:0] x, y, mu, mv;
  logic [30:0]        rho, en;
  logic               last, dfault, psat;
  logic signed [31:0] p;
  logic [63:0]        sq1, sq2;
  logic signed [63:0] diff;

  logic [31:0] m1, m2;
  logic [63:0] dmag;
  logic [64:0] p_prod;
  logic [31:0] p_quo;
  logic        div_start, div_done;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_divisor;

  assign m1    = mu[31] ? (32'd0 - $unsigned(mu)) : $unsigned(mu);
  assign m2    = mv[31] ? (32'd0 - $unsigned(mv)) : $unsigned(mv);
  assign dmag  = diff[63] ? (64'd0 - $unsigned(diff)) : $unsigned(diff);

  // Scaling by two fifths through the reciprocal; valid below the saturation magnitude.
  assign p_prod = {32'd0, dmag[32:0]} * {33'd0, PRESSURE_RECIP};
  assign p_quo  = p_prod[64:33];

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = '{x: x, y: y, pressure: p, last: last, dfault: dfault, psat: psat};

  assign div_start    = (state == F_KIN) && (rho != '0);
  assign div_dividend = sq1 + sq2;
  assign div_divisor  = {rho, 1'b0};

  spfi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (push) state_next = F_SQ;
      F_SQ:    state_next = F_KIN;
      F_KIN:   state_next = (rho == '0) ? F_PUSH : F_DIV1;
      F_DIV1:  if (div_done) state_next = F_SUB;
      F_SUB:   state_next = F_PUSH;
      F_PUSH:  if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (push) begin
          x      <= coord_x;
          y      <= coord_y;
          rho    <= density;
          mu     <= momentum_x;
          mv     <= momentum_y;
          en     <= energy_total;
          last   <= is_last;
          dfault <= 1'b0;
          psat   <= 1'b0;
          p      <= '0;
        end
      end
      F_SQ: begin
        sq1 <= {32'd0, m1} * {32'd0, m1};
        sq2 <= {32'd0, m2} * {32'd0, m2};
      end
      F_KIN: begin
        if (rho == '0) begin
          dfault <= 1'b1;
        end
      end
      F_DIV1: begin
        if (div_done) begin
          diff <= $signed({33'd0, en}) - $signed(div_q);
        end
      end
      F_SUB: begin
        if (diff[63]) begin
          // Only very negative values can leave the 32-bit pressure range.
          if (dmag >= PRESSURE_SAT_MAG) begin
            p    <= 32'sh8000_0000;
            psat <= 1'b1;
          end else begin
            p <= $signed(32'd0 - p_quo);
          end
        end else begin
          p <= $signed(p_quo);
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/spfi_fifo.sv
// Short point queue that decouples the pressure front from the integrating back.
// Depends on spfi_pkg.
module spfi_fifo import spfi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  point_t wdata,
  output logic   full,
  input  logic   rd,
  output point_t rdata,
  output logic   empty
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  point_t           slots [QDEPTH];
  logic [QAW-1:0]   wptr, rptr;
  logic [QCW-1:0]   count;
  logic             do_wr, do_rd;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == QAW'(QDEPTH - 1)) ? '0 : wptr + QAW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == QAW'(QDEPTH - 1)) ? '0 : rptr + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

FILE: rtl/core/spfi_mul.sv
// Shared sequential multiplier: 64x64 signed magnitude product from four 32x32 partial
// products, then a truncating right shift and saturation. Depends on spfi_pkg.
module spfi_mul import spfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mul_cmd_t           cmd,
  output logic               done,
  output logic signed [63:0] result,
  output logic               sat
);

  mul_state_t state, state_next;

  logic [63:0]  ua, ub, prod;
  logic         neg;
  logic [2:0]   cnt, pcnt;
  logic [127:0] acc, addend, sh;
  shift_t       shf;
  limit_t       lim;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [5:0]   lv;
  logic         upper_nz, at_lim;
  logic [63:0]  limv, res_n;
  logic         sat_n;

  assign a_part = cnt[0] ? ua[63:32] : ua[31:0];
  assign b_part = cnt[1] ? ub[63:32] : ub[31:0];
  assign pp     = {32'd0, a_part} * {32'd0, b_part};
  assign pcnt   = cnt - 3'd1;

  always_comb begin
    case (pcnt)
      3'd0:    addend = {64'd0, prod};
      3'd1,
      3'd2:    addend = {32'd0, prod, 32'd0};
      3'd3:    addend = {prod, 64'd0};
      default: addend = '0;
    endcase
  end

  always_comb begin
    case (shf)
      SH_FRAC:  sh = acc >> FRAC_BITS;
      SH_ANGLE: sh = acc >> ANGLE_FRAC;
      default:  sh = acc >> SCALE_FRAC;
    endcase
    case (lim)
      LIM_FULL: lv = 6'd63;
      LIM_ACC:  lv = 6'(ACC_WIDTH - 1);
      LIM_ROT:  lv = 6'd62;
      default:  lv = 6'd31;
    endcase
    upper_nz = |(sh >> lv);
    at_lim   = (sh == (128'd1 << lv));
    limv     = (64'd1 << lv) - 64'd1;
    if (neg) begin
      res_n = upper_nz ? ~limv : (64'd0 - sh[63:0]);
      sat_n = upper_nz && !at_lim;
    end else begin
      res_n = upper_nz ? limv : sh[63:0];
      sat_n = upper_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == M_FIN);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE:  if (start) state_next = M_RUN;
      M_RUN:   if (cnt == 3'd4) state_next = M_FIN;
      M_FIN:   state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          ua  <= cmd.a[63] ? (64'd0 - $unsigned(cmd.a)) : $unsigned(cmd.a);
          ub  <= cmd.b[63] ? (64'd0 - $unsigned(cmd.b)) : $unsigned(cmd.b);
          neg <= cmd.a[63] ^ cmd.b[63];
          shf <= cmd.shf;
          lim <= cmd.lim;
          cnt <= '0;
          acc <= '0;
        end
      end
      M_RUN: begin
        // Each partial product is registered and added in the next cycle.
        if (cnt != 3'd4) begin
          prod <= pp;
        end
        if (cnt != 3'd0) begin
          acc <= acc + addend;
        end
        cnt <= cnt + 3'd1;
      end
      M_FIN: begin
        result <= $signed(res_n);
        sat    <= sat_n;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/spfi_back.sv
// Back part: integrates segment forces and moment, then forms the coefficients on the last
// point and holds them in the result register. Depends on spfi_pkg and spfi_mul.
module spfi_back import spfi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  point_t             q_data,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] lift_coeff,
  output logic signed [31:0] drag_coeff,
  output logic signed [31:0] moment_coeff,
  output logic               density_fault,
  output logic               saturated
);

  back_state_t state, state_next;
  op_t         op, op_next;

  logic signed [31:0]          prev_x, prev_y, prev_p;
  logic                        have_prev;
  logic signed [ACC_WIDTH-1:0] fx_acc, fy_acc, mom_acc;
  logic [1:0]                  flags;
  logic                        cur_last;
  logic                        out_valid;

  logic signed [31:0] pm;
  logic signed [32:0] dx, dy, arm_x, arm_y;
  logic signed [63:0] lever, tmp, lift, drag;
  logic signed [31:0] cl, cd;

  logic [32:0] sum_p, sum_pa;
  logic [32:0] dx_n, dy_n;
  logic [33:0] armx_s, army_s, armx_a, army_a;

  logic               mul_start, mul_done, mul_sat;
  mul_cmd_t           mul_cmd;
  logic signed [63:0] mul_res;

  logic signed [ACC_WIDTH-1:0] acc_sel, term, acc_new;
  logic [ACC_WIDTH:0]          acc_sum;
  logic                        acc_ovf;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = !out_valid;

  // Segment quantities from the new point and the stored one; halving truncates toward zero.
  assign sum_p  = {q_data.pressure[31], q_data.pressure} + {prev_p[31], prev_p};
  assign sum_pa = sum_p + {32'd0, sum_p[32]};
  assign dx_n   = {q_data.x[31], q_data.x} - {prev_x[31], prev_x};
  assign dy_n   = {q_data.y[31], q_data.y} - {prev_y[31], prev_y};
  assign armx_s = {{2{q_data.x[31]}}, q_data.x} + {{2{prev_x[31]}}, prev_x}
                - {cfg.moment_ref_x[31], cfg.moment_ref_x, 1'b0};
  assign army_s = {{2{q_data.y[31]}}, q_data.y} + {{2{prev_y[31]}}, prev_y}
                - {cfg.moment_ref_y[31], cfg.moment_ref_y, 1'b0};
  assign armx_a = armx_s + {33'd0, armx_s[33]};
  assign army_a = army_s + {33'd0, army_s[33]};

  spfi_mul #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .cmd    (mul_cmd),
    .done   (mul_done),
    .result (mul_res),
    .sat    (mul_sat)
  );

  always_comb begin
    mul_start = (state == B_ISSUE);
    mul_cmd   = '0;
    case (op)
      OP_LEV_X:  mul_cmd = '{a: 64'(arm_x), b: 64'(dx), shf: SH_FRAC, lim: LIM_FULL};
      OP_LEV_Y:  mul_cmd = '{a: 64'(arm_y), b: 64'(dy), shf: SH_FRAC, lim: LIM_FULL};
      OP_FX:     mul_cmd = '{a: 64'(pm), b: 64'(dy), shf: SH_FRAC, lim: LIM_ACC};
      OP_FY:     mul_cmd = '{a: 64'(pm), b: -64'(dx), shf: SH_FRAC, lim: LIM_ACC};
      OP_MOM:    mul_cmd = '{a: 64'(pm), b: lever, shf: SH_FRAC, lim: LIM_ACC};
      OP_LIFT_C: mul_cmd = '{a: 64'(fy_acc), b: 64'(cfg.cos_incidence),
                             shf: SH_ANGLE, lim: LIM_ROT};
      OP_LIFT_S: mul_cmd = '{a: 64'(fx_acc), b: 64'(cfg.sin_incidence),
                             shf: SH_ANGLE, lim: LIM_ROT};
      OP_DRAG_S: mul_cmd = '{a: 64'(fy_acc), b: 64'(cfg.sin_incidence),
                             shf: SH_ANGLE, lim: LIM_ROT};
      OP_DRAG_C: mul_cmd = '{a: 64'(fx_acc), b: 64'(cfg.cos_incidence),
                             shf: SH_ANGLE, lim: LIM_ROT};
      OP_CL:     mul_cmd = '{a: lift, b: $signed({16'd0, cfg.coeff_scale}),
                             shf: SH_SCALE, lim: LIM_OUT};
      OP_CD:     mul_cmd = '{a: drag, b: $signed({16'd0, cfg.coeff_scale}),
                             shf: SH_SCALE, lim: LIM_OUT};
      OP_CM:     mul_cmd = '{a: 64'(mom_acc), b: $signed({16'd0, cfg.coeff_scale}),
                             shf: SH_SCALE, lim: LIM_OUT};
      default:   mul_cmd = '0;
    endcase
  end

  // Saturating accumulate; the term is already within the accumulator range.
  always_comb begin
    case (op)
      OP_FX:   acc_sel = fx_acc;
      OP_FY:   acc_sel = fy_acc;
      default: acc_sel = mom_acc;
    endcase
    term    = mul_res[ACC_WIDTH-1:0];
    acc_sum = {acc_sel[ACC_WIDTH-1], acc_sel} + {term[ACC_WIDTH-1], term};
    acc_ovf = acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1];
    if (acc_ovf) begin
      acc_new = acc_sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                   : {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end else begin
      acc_new = acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (have_prev) begin
            op_next    = OP_LEV_X;
            state_next = B_ISSUE;
          end else if (q_data.last) begin
            op_next    = OP_LIFT_C;
            state_next = B_ISSUE;
          end
        end
      end
      B_ISSUE: state_next = B_WAIT;
      B_WAIT: begin
        if (mul_done) begin
          state_next = B_ISSUE;
          case (op)
            OP_LEV_X:  op_next = OP_LEV_Y;
            OP_LEV_Y:  op_next = OP_FX;
            OP_FX:     op_next = OP_FY;
            OP_FY:     op_next = OP_MOM;
            OP_MOM: begin
              if (cur_last) begin
                op_next = OP_LIFT_C;
              end else begin
                state_next = B_IDLE;
              end
            end
            OP_LIFT_C: op_next = OP_LIFT_S;
            OP_LIFT_S: op_next = OP_DRAG_S;
            OP_DRAG_S: op_next = OP_DRAG_C;
            OP_DRAG_C: op_next = OP_CL;
            OP_CL:     op_next = OP_CD;
            OP_CD:     op_next = OP_CM;
            default:   state_next = B_OUT;
          endcase
        end
      end
      B_OUT:   if (!out_valid) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      op        <= OP_LEV_X;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_p    <= '0;
      have_prev <= 1'b0;
      fx_acc    <= '0;
      fy_acc    <= '0;
      mom_acc   <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            prev_x    <= q_data.x;
            prev_y    <= q_data.y;
            prev_p    <= q_data.pressure;
            have_prev <= 1'b1;
            flags     <= flags | {q_data.psat, q_data.dfault};
          end
        end
        B_WAIT: begin
          if (mul_done) begin
            if (mul_sat || (acc_ovf && (op == OP_FX || op == OP_FY || op == OP_MOM))) begin
              flags[1] <= 1'b1;
            end
            case (op)
              OP_FX:   fx_acc  <= acc_new;
              OP_FY:   fy_acc  <= acc_new;
              OP_MOM:  mom_acc <= acc_new;
              default: ;
            endcase
          end
        end
        B_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            prev_x    <= '0;
            prev_y    <= '0;
            prev_p    <= '0;
            have_prev <= 1'b0;
            fx_acc    <= '0;
            fy_acc    <= '0;
            mom_acc   <= '0;
            flags     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pm       <= $signed(sum_pa[32:1]);
          dx       <= $signed(dx_n);
          dy       <= $signed(dy_n);
          arm_x    <= $signed(armx_a[33:1]);
          arm_y    <= $signed(army_a[33:1]);
          cur_last <= q_data.last;
        end
      end
      B_WAIT: begin
        if (mul_done) begin
          case (op)
            OP_LEV_X:  lever <= mul_res;
            OP_LEV_Y:  lever <= lever + mul_res;
            OP_LIFT_C: tmp   <= mul_res;
            OP_LIFT_S: lift  <= tmp - mul_res;
            OP_DRAG_S: tmp   <= mul_res;
            OP_DRAG_C: drag  <= tmp + mul_res;
            OP_CL:     cl    <= mul_res[31:0];
            OP_CD:     cd    <= mul_res[31:0];
            OP_CM:     tmp   <= mul_res;
            default:   ;
          endcase
        end
      end
      B_OUT: begin
        if (!out_valid) begin
          lift_coeff    <= cl;
          drag_coeff    <= cd;
          moment_coeff  <= tmp[31:0];
          density_fault <= flags[0];
          saturated     <= flags[1];
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == B_WAIT))
    else $error("multiplier finished outside of the wait state");

  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && !out_valid) |=> (out_valid && !have_prev && flags == 2'b00))
    else $error("result load did not clear the surface state");

  a_rose_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == B_OUT))
    else $error("result register loaded outside of the output state");
`endif

endmodule
